### src/fvts_pkg.sv
// Package for the frequency/voltage transition sequencer.
// Holds payload structs, mode, status and register codes and the sequencer state type.
// No dependencies.
`default_nettype none
package fvts_pkg;

   localparam int FIDW = 6;
   localparam int VIDW = 5;
   localparam int MAX_WRITES = 63;

   // Configuration register indexes.
   localparam logic [2:0] REG_SETTLE = 3'd0;
   localparam logic [2:0] REG_RAMP   = 3'd1;
   localparam logic [2:0] REG_RELIEF = 3'd2;
   localparam logic [2:0] REG_VSTEP  = 3'd3;
   localparam logic [2:0] REG_LOCK   = 3'd4;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_REQ   = 2'd1,
      MODE_SET   = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_AT_PT   = 3'd1,
      ST_NOMATCH = 3'd2,
      ST_FULL    = 3'd3,
      ST_OVERRUN = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_WAIT,
      S_INS_CHK,
      S_SRCH_RD,
      S_SRCH_WAIT,
      S_SRCH_CHK,
      S_VDOWN,
      S_VRAMP,
      S_FSTEP,
      S_FFINAL,
      S_VFINAL,
      S_DONE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [12:0] req_freq_mhz;
      logic [5:0]  fid_code;
      logic [4:0]  vid_code;
   } req_type;

   typedef struct packed {
      logic        cmd_valid;
      logic [5:0]  cmd_fid;
      logic [4:0]  cmd_vid;
      logic [15:0] cmd_count;
      logic [20:0] wait_us;
      logic [12:0] speed_mhz;
      logic [2:0]  status_code;
      logic        last;
   } rsp_type;

   // Frequency code to MHz: 800 + 100 * fid.
   function automatic logic [12:0] freq_of(input logic [5:0] fid);
      logic [12:0] f;
      f = 13'd800 + 13'(fid) * 13'd100;
      return f;
   endfunction

   function automatic logic [6:0] vco_of(input logic [5:0] fid);
      logic [6:0] v;
      v = (fid < 6'd8) ? (7'd8 + {fid, 1'b0}) : {1'b0, fid};
      return v;
   endfunction

endpackage
`default_nettype wire

### src/fid_vid_transition_sequencer_core.sv
// Top level of the frequency/voltage transition sequencer.
// Operating-point table in one synchronous memory; uses fvts_pkg.
//
// Sequencing: a load reads, waits on and checks each entry it shifts, a
// request each table entry it searches. A request then walks its sequence
// twice: a counting pass through each control write or phase change, then
// the emitting pass, where each write waits out its transfer and any stall.
// One item is in work at a time; the next is taken after the final transfer.
// Reset: synchronous; clears count, current point, speed and registers.
`default_nettype none
module fid_vid_transition_sequencer_core
   import fvts_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // Table memory: {fid, vid} per entry.
   logic [10:0] mem [TABLE_DEPTH];
   logic [10:0] rd_data_ff;
   logic        mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [10:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   logic [15:0] vst_ff;
   logic [1:0]  rvo_ff, irt_ff, mvs_ff;
   logic [7:0]  plt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vst_ff <= '0; rvo_ff <= '0; irt_ff <= '0; mvs_ff <= '0; plt_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SETTLE: vst_ff <= csr_wdata;
            REG_RAMP:   rvo_ff <= csr_wdata[1:0];
            REG_RELIEF: irt_ff <= csr_wdata[1:0];
            REG_VSTEP:  mvs_ff <= csr_wdata[1:0];
            REG_LOCK:   plt_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [5:0]  cfid_ff, cfid_in, tfid_ff, tfid_in;
   logic [4:0]  cvid_ff, cvid_in, tvid_ff, tvid_in;
   logic [12:0] speed_ff, speed_in;
   req_type     item_ff, item_in;
   logic [1:0]  ramp_ff, ramp_in;
   logic [5:0]  nwr_ff, nwr_in;
   logic        rv_ff, rv_in;
   rsp_type     rsp_ff, rsp_in;
   logic        dry_ff, dry_in;
   logic        ovr_ff, ovr_in;
   logic [5:0]  total_ff, total_in;
   logic [5:0]  sfid_ff, sfid_in;
   logic [4:0]  svid_ff, svid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         cfid_ff  <= '0;
         cvid_ff  <= '0;
         speed_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cfid_ff  <= cfid_in;
         cvid_ff  <= cvid_in;
         speed_ff <= speed_in;
         rv_ff    <= rv_in;
      end
      idx_ff   <= idx_in;
      tfid_ff  <= tfid_in;
      tvid_ff  <= tvid_in;
      item_ff  <= item_in;
      ramp_ff  <= ramp_in;
      nwr_ff   <= nwr_in;
      rsp_ff   <= rsp_in;
      dry_ff   <= dry_in;
      ovr_ff   <= ovr_in;
      total_ff <= total_in;
      sfid_ff  <= sfid_in;
      svid_ff  <= svid_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   logic [5:0] rd_fid;
   logic [4:0] rd_vid;
   assign rd_fid = rd_data_ff[10:5];
   assign rd_vid = rd_data_ff[4:0];

   logic [5:0]  vstep;
   logic [6:0]  vt, vc, vdiff;
   logic [5:0]  nf;
   logic [20:0] vwait, fwait;
   logic [15:0] fcount;
   assign vstep  = 6'd1 << mvs_ff;
   assign vt     = vco_of(tfid_ff);
   assign vc     = vco_of(cfid_ff);
   assign vdiff  = (vt >= vc) ? (vt - vc) : (vc - vt);
   assign nf     = (tfid_ff > cfid_ff) ?
                   ((cfid_ff > 6'd6) ? cfid_ff + 6'd2 : 6'(vc + 7'd2)) :
                   ((cfid_ff >= 6'd2) ? cfid_ff - 6'd2 : 6'd0);
   assign vwait  = 21'(vst_ff) * 21'd20;
   assign fwait  = 21'd10 << irt_ff;
   assign fcount = 16'(plt_ff) * 16'd200;

   // Sequencer: a request walks its sequence once without output to count the
   // writes and spot an overrun, then rewinds and walks it again, emitting one
   // write into the output register and waiting for its transfer each time.
   always_comb begin
      logic [5:0] nv;
      nv = (6'(cvid_ff) > vstep) ? 6'(cvid_ff) - vstep : 6'd0;
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      cfid_in  = cfid_ff;
      cvid_in  = cvid_ff;
      tfid_in  = tfid_ff;
      tvid_in  = tvid_ff;
      speed_in = speed_ff;
      item_in  = item_ff;
      ramp_in  = ramp_ff;
      nwr_in   = nwr_ff;
      rv_in    = rv_ff;
      rsp_in   = rsp_ff;
      dry_in   = dry_ff;
      ovr_in   = ovr_ff;
      total_in = total_ff;
      sfid_in  = sfid_ff;
      svid_in  = svid_ff;
      mem_we    = 1'b0;
      mem_waddr = idx_ff[AW-1:0];
      mem_wdata = {item_ff.fid_code, item_ff.vid_code};
      mem_raddr = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               rsp_in  = '0;
               rsp_in.last = 1'b1;
               nwr_in  = '0;
               case (mode_type'(req_data.mode))
                  MODE_LOAD: begin
                     if (count_ff >= CW'(TABLE_DEPTH)) begin
                        rsp_in.status_code = ST_FULL;
                        rsp_in.speed_mhz = speed_ff;
                        rv_in = 1'b1;
                        state_in = S_OUT;
                     end else begin
                        idx_in = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  MODE_REQ: begin
                     idx_in = '0;
                     state_in = S_SRCH_RD;
                  end
                  MODE_SET: begin
                     cfid_in = req_data.fid_code;
                     cvid_in = req_data.vid_code;
                     rsp_in.speed_mhz = speed_ff;
                     rv_in = 1'b1;
                     state_in = S_OUT;
                  end
                  default: begin
                     count_in = '0;
                     rsp_in.speed_mhz = speed_ff;
                     rv_in = 1'b1;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (idx_ff == '0) begin
               mem_we = 1'b1;
               count_in = count_ff + 1'b1;
               rsp_in.speed_mhz = speed_ff;
               rv_in = 1'b1;
               state_in = S_OUT;
            end else begin
               mem_raddr = AW'(idx_ff - 1'b1);
               state_in = S_INS_WAIT;
            end
         end
         S_INS_WAIT: begin
            mem_raddr = AW'(idx_ff - 1'b1);
            state_in = S_INS_CHK;
         end
         S_INS_CHK: begin
            if (freq_of(rd_fid) > freq_of(item_ff.fid_code)) begin
               mem_we = 1'b1;
               mem_wdata = rd_data_ff;
               idx_in = idx_ff - 1'b1;
               state_in = S_INS_RD;
            end else begin
               mem_we = 1'b1;
               count_in = count_ff + 1'b1;
               rsp_in.speed_mhz = speed_ff;
               rv_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_SRCH_RD: begin
            if (idx_ff >= count_ff) begin
               rsp_in.status_code = ST_NOMATCH;
               rsp_in.speed_mhz = speed_ff;
               rv_in = 1'b1;
               state_in = S_OUT;
            end else begin
               mem_raddr = idx_ff[AW-1:0];
               state_in = S_SRCH_WAIT;
            end
         end
         S_SRCH_WAIT: begin
            mem_raddr = idx_ff[AW-1:0];
            state_in = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            if (freq_of(rd_fid) >= item_ff.req_freq_mhz) begin
               tfid_in = rd_fid;
               tvid_in = rd_vid;
               ramp_in = rvo_ff;
               if (rd_fid == cfid_ff && rd_vid == cvid_ff) begin
                  speed_in = item_ff.req_freq_mhz;
                  rsp_in.status_code = ST_AT_PT;
                  rsp_in.speed_mhz = item_ff.req_freq_mhz;
                  rv_in = 1'b1;
                  state_in = S_OUT;
               end else begin
                  dry_in  = 1'b1;
                  ovr_in  = 1'b0;
                  sfid_in = cfid_ff;
                  svid_in = cvid_ff;
                  state_in = S_VDOWN;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_SRCH_RD;
            end
         end
         S_VDOWN, S_VRAMP, S_FSTEP, S_FFINAL, S_VFINAL: begin
            // One write per pass; sequence proceeds when the output is free.
            if (!rv_ff) begin
               rsp_in = '0;
               rsp_in.cmd_valid = 1'b1;
               rsp_in.speed_mhz = speed_ff;
               if (state_ff == S_VDOWN && cvid_ff > tvid_ff) begin
                  rsp_in.cmd_fid = cfid_ff; rsp_in.cmd_vid = nv[4:0];
                  rsp_in.cmd_count = 16'd1; rsp_in.wait_us = vwait;
                  cvid_in = nv[4:0];
               end else if (state_ff == S_VDOWN) begin
                  state_in = S_VRAMP;
                  rsp_in.cmd_valid = 1'b0;
               end else if (state_ff == S_VRAMP && ramp_ff != '0 && cvid_ff != '0) begin
                  rsp_in.cmd_fid = cfid_ff; rsp_in.cmd_vid = cvid_ff - 1'b1;
                  rsp_in.cmd_count = 16'd1; rsp_in.wait_us = vwait;
                  cvid_in = cvid_ff - 1'b1;
                  ramp_in = ramp_ff - 1'b1;
               end else if (state_ff == S_VRAMP) begin
                  state_in = (cfid_ff != tfid_ff) ? S_FSTEP : S_VFINAL;
                  rsp_in.cmd_valid = 1'b0;
               end else if (state_ff == S_FSTEP && vdiff > 7'd2) begin
                  rsp_in.cmd_fid = nf; rsp_in.cmd_vid = cvid_ff;
                  rsp_in.cmd_count = fcount; rsp_in.wait_us = fwait;
                  cfid_in = nf;
               end else if (state_ff == S_FSTEP) begin
                  state_in = S_FFINAL;
                  rsp_in.cmd_valid = 1'b0;
               end else if (state_ff == S_FFINAL) begin
                  rsp_in.cmd_fid = tfid_ff; rsp_in.cmd_vid = cvid_ff;
                  rsp_in.cmd_count = fcount; rsp_in.wait_us = fwait;
                  cfid_in = tfid_ff;
                  state_in = S_VFINAL;
               end else if (cvid_ff != tvid_ff) begin
                  rsp_in.cmd_fid = cfid_ff; rsp_in.cmd_vid = tvid_ff;
                  rsp_in.cmd_count = 16'd1; rsp_in.wait_us = vwait;
                  cvid_in = tvid_ff;
                  state_in = S_DONE;
               end else begin
                  state_in = S_DONE;
                  rsp_in.cmd_valid = 1'b0;
               end
               if (rsp_in.cmd_valid) begin
                  if (nwr_ff == 6'(MAX_WRITES)) begin
                     cfid_in = cfid_ff;
                     cvid_in = cvid_ff;
                     if (dry_ff) begin
                        ovr_in = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        // Write budget spent: report the overrun.
                        rsp_in = '0;
                        rsp_in.status_code = ST_OVERRUN;
                        rsp_in.speed_mhz = speed_ff;
                        rsp_in.last = 1'b1;
                        rv_in = 1'b1;
                        state_in = S_OUT;
                     end
                  end else begin
                     nwr_in = nwr_ff + 1'b1;
                     if (!dry_ff) begin
                        // A completed sequence reports the new speed on every write.
                        rsp_in.speed_mhz = ovr_ff ? speed_ff : freq_of(tfid_ff);
                        if (!ovr_ff && nwr_in == total_ff) begin
                           rsp_in.last = 1'b1;
                           speed_in = freq_of(tfid_ff);
                           state_in = S_OUT;
                        end
                        rv_in = 1'b1;
                     end
                  end
               end
            end else if (rsp_ready) begin
               rv_in = 1'b0;
            end
         end
         S_DONE: begin
            // Counting pass finished: rewind to the starting point and emit.
            cfid_in  = sfid_ff;
            cvid_in  = svid_ff;
            ramp_in  = rvo_ff;
            total_in = nwr_ff;
            nwr_in   = '0;
            dry_in   = 1'b0;
            state_in = S_VDOWN;
         end
         S_OUT: begin
            if (rsp_ready) begin
               rv_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### src/fvts_checker.sv
// Port-level checker for the transition sequencer, bound to the top level.
// Uses fvts_pkg for payload and status codes.
`default_nettype none
module fvts_port_props
   import fvts_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !req_ready)
      else $error("input taken mid sequence");
   a_idle_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.cmd_valid |-> rsp_data.last && rsp_data.cmd_count == 16'd0)
      else $error("non-write result malformed");
   a_write_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cmd_valid |-> rsp_data.status_code == ST_OK)
      else $error("write carries status");
endmodule

bind fid_vid_transition_sequencer_core fvts_port_props u_fvts_port_props (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));
`default_nettype wire

### dv/fvts_checker.sv
// Checker for the frequency/voltage transition sequencer: watches both channels,
// predicts the control writes of each request and compares them with the block.
// Depends on fvts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fvts_checker
   import fvts_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire req_type     req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire rsp_type     rsp_data,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);

   logic [5:0]  op_fid [TABLE_DEPTH];
   logic [4:0]  op_vid [TABLE_DEPTH];
   int          n_points;
   logic [5:0]  cur_fid;
   logic [4:0]  cur_vid;
   logic [12:0] cur_speed;

   logic [15:0] settle_unit;
   logic [1:0]  extra_steps;
   logic [1:0]  relief_code;
   logic [1:0]  vstep_code;
   logic [7:0]  lock_time;

   rsp_type expected_writes[$];
   rsp_type seq_buf[$];

   assign pending_count = expected_writes.size();

   function automatic int mhz_of(input logic [5:0] fid);
      return 800 + 100 * int'(fid);
   endfunction

   function automatic int vco_point(input logic [5:0] fid);
      return (fid < 8) ? 8 + 2 * int'(fid) : int'(fid);
   endfunction

   function automatic rsp_type status_only(input status_type st);
      rsp_type r;
      r = '0;
      r.status_code = st;
      r.last = 1'b1;
      return r;
   endfunction

   // Appends one control write; returns 0 once the write budget is used up.
   function automatic bit push_write(input logic [5:0] fid, input logic [4:0] vid,
                                     input bit is_freq);
      rsp_type r;
      if (seq_buf.size() >= MAX_WRITES) return 1'b0;
      r = '0;
      r.cmd_valid = 1'b1;
      r.cmd_fid = fid;
      r.cmd_vid = vid;
      if (is_freq) begin
         r.cmd_count = 16'(int'(lock_time) * 200);
         r.wait_us = 21'(10 << relief_code);
      end else begin
         r.cmd_count = 16'd1;
         r.wait_us = 21'(20 * int'(settle_unit));
      end
      seq_buf.push_back(r);
      return 1'b1;
   endfunction

   task automatic predict_request(input logic [12:0] want);
      logic [5:0] tf, cf, nf;
      logic [4:0] tv, cv;
      bit found, ok;
      int v, d;
      found = 1'b0;
      ok = 1'b1;
      tf = '0;
      tv = '0;
      cf = cur_fid;
      cv = cur_vid;
      seq_buf.delete();
      for (int i = 0; i < n_points; i++) begin
         if (!found && mhz_of(op_fid[i]) >= int'(want)) begin
            tf = op_fid[i];
            tv = op_vid[i];
            found = 1'b1;
         end
      end
      if (!found) begin
         expected_writes.push_back(status_only(ST_NOMATCH));
         expected_writes[$].speed_mhz = cur_speed;
         return;
      end
      if (tf == cf && tv == cv) begin
         cur_speed = want;
         expected_writes.push_back(status_only(ST_AT_PT));
         expected_writes[$].speed_mhz = cur_speed;
         return;
      end
      while (ok && cv > tv) begin
         v = int'(cv) - (1 << vstep_code);
         if (v < 0) v = 0;
         ok = push_write(cf, 5'(v), 1'b0);
         if (ok) cv = 5'(v);
      end
      for (int i = extra_steps; ok && i > 0 && cv > 0; i--) begin
         ok = push_write(cf, cv - 5'd1, 1'b0);
         if (ok) cv = cv - 5'd1;
      end
      if (ok && cf != tf) begin
         forever begin
            d = vco_point(tf) - vco_point(cf);
            if (d < 0) d = -d;
            if (d <= 2) break;
            if (tf > cf) nf = (cf > 6) ? cf + 6'd2 : 6'(vco_point(cf) + 2);
            else nf = (cf >= 2) ? cf - 6'd2 : 6'd0;
            ok = push_write(nf, cv, 1'b1);
            if (!ok) break;
            cf = nf;
         end
         if (ok) begin
            ok = push_write(tf, cv, 1'b1);
            if (ok) cf = tf;
         end
      end
      if (ok && cv != tv) begin
         ok = push_write(cf, tv, 1'b0);
         if (ok) cv = tv;
      end
      cur_fid = cf;
      cur_vid = cv;
      if (!ok) seq_buf.push_back(status_only(ST_OVERRUN));
      else begin
         cur_speed = 13'(mhz_of(tf));
         seq_buf[$].last = 1'b1;
      end
      foreach (seq_buf[k]) begin
         seq_buf[k].speed_mhz = cur_speed;
         expected_writes.push_back(seq_buf[k]);
      end
   endtask

   task automatic predict_item(input req_type it);
      int j;
      case (mode_type'(it.mode))
         MODE_LOAD: begin
            if (n_points >= TABLE_DEPTH) begin
               expected_writes.push_back(status_only(ST_FULL));
            end else begin
               j = n_points;
               while (j > 0 && mhz_of(op_fid[j-1]) > mhz_of(it.fid_code)) begin
                  op_fid[j] = op_fid[j-1];
                  op_vid[j] = op_vid[j-1];
                  j--;
               end
               op_fid[j] = it.fid_code;
               op_vid[j] = it.vid_code;
               n_points++;
               expected_writes.push_back(status_only(ST_OK));
            end
            expected_writes[$].speed_mhz = cur_speed;
         end
         MODE_REQ: predict_request(it.req_freq_mhz);
         MODE_SET: begin
            cur_fid = it.fid_code;
            cur_vid = it.vid_code;
            expected_writes.push_back(status_only(ST_OK));
            expected_writes[$].speed_mhz = cur_speed;
         end
         default: begin
            n_points = 0;
            expected_writes.push_back(status_only(ST_OK));
            expected_writes[$].speed_mhz = cur_speed;
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic compare_result(input rsp_type got);
      rsp_type exp;
      if (expected_writes.size() == 0) begin
         report_mismatch("unexpected result transfer", 1, 0);
         return;
      end
      exp = expected_writes.pop_front();
      if (got.cmd_valid !== exp.cmd_valid) report_mismatch("cmd_valid", got.cmd_valid, exp.cmd_valid);
      if (got.cmd_fid !== exp.cmd_fid) report_mismatch("cmd_fid", got.cmd_fid, exp.cmd_fid);
      if (got.cmd_vid !== exp.cmd_vid) report_mismatch("cmd_vid", got.cmd_vid, exp.cmd_vid);
      if (got.cmd_count !== exp.cmd_count)
         report_mismatch("cmd_count", got.cmd_count, exp.cmd_count);
      if (got.wait_us !== exp.wait_us) report_mismatch("wait_us", got.wait_us, exp.wait_us);
      if (got.speed_mhz !== exp.speed_mhz)
         report_mismatch("speed_mhz", got.speed_mhz, exp.speed_mhz);
      if (got.status_code !== exp.status_code)
         report_mismatch("status_code", got.status_code, exp.status_code);
      if (got.last !== exp.last) report_mismatch("last", got.last, exp.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         n_points = 0;
         cur_fid = '0;
         cur_vid = '0;
         cur_speed = '0;
         settle_unit = '0;
         extra_steps = '0;
         relief_code = '0;
         vstep_code = '0;
         lock_time = '0;
         fail_count = 0;
         expected_writes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SETTLE: settle_unit = csr_wdata;
               REG_RAMP:   extra_steps = csr_wdata[1:0];
               REG_RELIEF: relief_code = csr_wdata[1:0];
               REG_VSTEP:  vstep_code = csr_wdata[1:0];
               REG_LOCK:   lock_time = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) compare_result(rsp_data);
         if (req_valid && req_ready) predict_item(req_data);
      end
   end

endmodule
`default_nettype wire

### dv/tb_top.sv
// Testbench top for the frequency/voltage transition sequencer: makes stimulus,
// random stalls and register settings, and gives the verdict.
// Depends on fvts_pkg, fvts_checker and the sequencer core.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import fvts_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   bit          stall_enable = 1'b1;

   always #5 clock = ~clock;

   fid_vid_transition_sequencer_core DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   fvts_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending_count
   );

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Receiver stalls at random, with stall-free stretches.
   always @(posedge clock) begin
      if (reset || !stall_enable) rsp_ready <= 1'b1;
      else if ($urandom_range(0, 15) == 0) rsp_ready <= 1'b0;
      else if ($urandom_range(0, 99) < 8) rsp_ready <= 1'b0;
      else rsp_ready <= 1'b1;
   end

   // Valid stays high into the next item when there is no gap.
   task automatic send_item(input mode_type m, input logic [12:0] freq,
                            input logic [5:0] fid, input logic [4:0] vid);
      int g;
      g = gap_length();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_data <= '{mode: m, req_freq_mhz: freq, fid_code: fid, vid_code: vid};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input int idx, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= 3'(idx);
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_regs(input logic [15:0] settle, input logic [1:0] ramp,
                           input logic [1:0] relief, input logic [1:0] vstep,
                           input logic [7:0] lock);
      write_reg(REG_SETTLE, settle);
      write_reg(REG_RAMP, 16'(ramp));
      write_reg(REG_RELIEF, 16'(relief));
      write_reg(REG_VSTEP, 16'(vstep));
      write_reg(REG_LOCK, 16'(lock));
   endtask

   // A phase: fresh table, a known current point, then mostly requests.
   task automatic table_phase(input int n_req);
      int n_load;
      send_item(MODE_CLEAR, 13'($urandom), 6'($urandom), 5'($urandom));
      n_load = $urandom_range(1, 17);
      for (int i = 0; i < n_load; i++)
         send_item(MODE_LOAD, 13'($urandom), 6'($urandom), 5'($urandom));
      send_item(MODE_SET, 13'($urandom), 6'($urandom), 5'($urandom));
      for (int i = 0; i < n_req; i++) begin
         case ($urandom_range(0, 9))
            0: send_item(MODE_SET, 13'($urandom), 6'($urandom), 5'($urandom));
            1: send_item(mode_type'($urandom_range(0, 3)), 13'($urandom),
                         6'($urandom), 5'($urandom));
            2: send_item(MODE_REQ, 13'($urandom_range(7101, 8191)), 6'($urandom),
                         5'($urandom));
            default: send_item(MODE_REQ, 13'($urandom_range(0, 7100)),
                               6'($urandom), 5'($urandom));
         endcase
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme codes, full table, no match, already at point.
      set_regs(16'hFFFF, 2'd3, 2'd3, 2'd3, 8'hFF);
      send_item(MODE_REQ, 13'd800, 6'd0, 5'd0);
      for (int i = 0; i < 16; i++)
         send_item(MODE_LOAD, 13'h1FFF, 6'(63 - 4 * i), 5'(i * 2));
      send_item(MODE_LOAD, 13'd0, 6'd10, 5'd3);
      send_item(MODE_REQ, 13'd7101, 6'd0, 5'd0);
      send_item(MODE_SET, 13'd0, 6'd0, 5'd31);
      send_item(MODE_REQ, 13'd0, 6'd0, 5'd0);
      send_item(MODE_REQ, 13'd7100, 6'd0, 5'd0);
      send_item(MODE_REQ, 13'd7100, 6'd0, 5'd0);
      send_item(MODE_CLEAR, 13'd0, 6'd63, 5'd31);
      drain();
      // Long ramp with single-step voltage moves that stays within the write budget.
      set_regs(16'd0, 2'd3, 2'd0, 2'd0, 8'd0);
      send_item(MODE_LOAD, 13'd0, 6'd0, 5'd3);
      send_item(MODE_SET, 13'd0, 6'd63, 5'd31);
      send_item(MODE_REQ, 13'd0, 6'd0, 5'd0);
      drain();

      for (int p = 0; p < 12; p++) begin
         set_regs(16'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
                  8'($urandom));
         stall_enable = (p % 4 != 3);
         table_phase(14);
         drain();
      end
      set_regs(16'd0, 2'd0, 2'd0, 2'd0, 8'd0);
      table_phase(10);
      drain();

      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire
